@@ hdl/att_pkg.sv @@
// Package for the ANSI text terminal: geometry, parser modes, CSI codes and handy functions.
// No dependencies.
`timescale 1ns / 1ps
package att_pkg;
    localparam int COLUMNS          = 80;
    localparam int ROWS             = 25;
    localparam int MAX_PARAMS       = 8;
    localparam int SEQ_BUFFER_BYTES = 32;
    localparam int CELLS            = COLUMNS * ROWS;
    localparam int ADDR_W           = $clog2(CELLS);
    localparam int COL_W            = 7;
    localparam int ROW_W            = 5;
    localparam int PIDX_W           = $clog2(MAX_PARAMS + 1);
    localparam int PSEL_W           = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int SLEN_W           = $clog2(SEQ_BUFFER_BYTES);
    localparam int PVAL_W           = 14;
    localparam logic [PVAL_W-1:0] PARAM_MAX = 14'd16383;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] FIN_H    = 8'h48;
    localparam logic [7:0] FIN_F    = 8'h66;
    localparam logic [7:0] FIN_J    = 8'h4A;
    localparam logic [7:0] FIN_M    = 8'h6D;

    localparam logic CFG_FG = 1'b0;
    localparam logic CFG_BG = 1'b1;

    typedef enum logic [1:0] {MODE_GROUND, MODE_ESC, MODE_CSI} mode_t;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_SGR, ST_GLYPH, ST_SCROLL, ST_READ, ST_OUT
    } state_t;

    function automatic logic [ROW_W-1:0] pos_row(input logic [PVAL_W-1:0] v);
        logic [PVAL_W-1:0] t;
        t = (v == '0) ? '0 : v - 1'b1;
        return (t >= PVAL_W'(ROWS)) ? ROW_W'(ROWS - 1) : t[ROW_W-1:0];
    endfunction

    function automatic logic [COL_W-1:0] pos_col(input logic [PVAL_W-1:0] v);
        logic [PVAL_W-1:0] t;
        t = (v == '0) ? '0 : v - 1'b1;
        return (t >= PVAL_W'(COLUMNS)) ? COL_W'(COLUMNS - 1) : t[COL_W-1:0];
    endfunction
endpackage

@@ hdl/ansi_text_terminal.sv @@
// ANSI text terminal: byte-stream parser, cursor and colors over a ring-ordered cell memory.
// Uses att_pkg. An ESC not followed by [ is printed and the next byte replayed; a wrap with scroll
// blanks one row, ESC[2J blanks all COLUMNS*ROWS cells, and SGR steps through its parameters.
// One word at a time; in_stall holds while a word is in work or its result waits.
// Reset: a clearing pass fills the memory with blank cells; no word is accepted.
`timescale 1ns / 1ps
module ansi_text_terminal (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_index,
    input  logic [3:0]                 cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       func,
    input  logic [7:0]                 data_byte,
    input  logic [6:0]                 read_column,
    input  logic [4:0]                 read_row,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [att_pkg::COL_W-1:0]  cursor_column,
    output logic [att_pkg::ROW_W-1:0]  cursor_row,
    output logic [7:0]                 cell_character,
    output logic [7:0]                 cell_attribute
);
    import att_pkg::*;

    logic [15:0] mem [CELLS];
    logic [15:0] rd_data_reg;

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;
    logic [3:0] dfg_reg, dbg_reg, fg_reg, fg_next, bg_reg, bg_next;
    logic [ROW_W-1:0] top_reg, top_next, crow_reg, crow_next;
    logic [COL_W-1:0] ccol_reg, ccol_next;
    logic [PVAL_W-1:0] pv_reg [MAX_PARAMS];
    logic [PVAL_W-1:0] pv_next [MAX_PARAMS];
    logic [PIDX_W-1:0] pidx_reg, pidx_next;
    logic [SLEN_W-1:0] slen_reg, slen_next;
    logic inv_reg, inv_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic [PSEL_W-1:0] sgr_reg, sgr_next;
    logic [7:0] pend_reg, pend_next;
    logic pend_v_reg, pend_v_next;
    logic boot_reg, boot_next;
    logic [7:0] och_reg, och_next, oat_reg, oat_next;
    logic [ADDR_W-1:0] ring_base_reg, ring_base_next;

    logic        we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [15:0] wdata;

    logic [7:0] attr;
    logic [7:0] byte_c;
    logic [ROW_W-1:0] rr;
    logic [ADDR_W-1:0] cur_addr;
    logic [PVAL_W-1:0] sv;
    logic [PVAL_W+3:0] prod;
    logic [PSEL_W-1:0] pi;

    assign attr = {bg_reg, fg_reg};

    function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] r,
                                                  input logic [ROW_W-1:0] top,
                                                  input logic [COL_W-1:0] c);
        logic [ROW_W:0] s;
        s = {1'b0, r} + {1'b0, top};
        if (s >= (ROW_W+1)'(ROWS))
            s = s - (ROW_W+1)'(ROWS);
        return ADDR_W'(s[ROW_W-1:0] * COLUMNS) + ADDR_W'(c);
    endfunction

    assign cur_addr = addr_of(crow_reg, top_reg, ccol_reg);
    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE) || pend_v_reg;
    assign out_valid = (state_reg == ST_OUT);
    assign cursor_column  = ccol_reg;
    assign cursor_row     = crow_reg;
    assign cell_character = och_reg;
    assign cell_attribute = oat_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_data_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            mode_reg   <= MODE_GROUND;
            dfg_reg    <= 4'd15;
            dbg_reg    <= 4'd1;
            fg_reg     <= 4'd15;
            bg_reg     <= 4'd1;
            top_reg    <= '0;
            crow_reg   <= '0;
            ccol_reg   <= '0;
            for (int i = 0; i < MAX_PARAMS; i++)
                pv_reg[i] <= '0;
            pidx_reg   <= '0;
            slen_reg   <= '0;
            inv_reg    <= 1'b0;
            sweep_reg  <= '0;
            sgr_reg    <= '0;
            pend_v_reg <= 1'b0;
            boot_reg   <= 1'b1;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            fg_reg     <= fg_next;
            bg_reg     <= bg_next;
            top_reg    <= top_next;
            crow_reg   <= crow_next;
            ccol_reg   <= ccol_next;
            for (int i = 0; i < MAX_PARAMS; i++)
                pv_reg[i] <= pv_next[i];
            pidx_reg   <= pidx_next;
            slen_reg   <= slen_next;
            inv_reg    <= inv_next;
            sweep_reg  <= sweep_next;
            sgr_reg    <= sgr_next;
            pend_v_reg <= pend_v_next;
            boot_reg   <= boot_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_FG)
                    dfg_reg <= cfg_data;
                else
                    dbg_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg      <= pend_next;
        och_reg       <= och_next;
        oat_reg       <= oat_next;
        ring_base_reg <= ring_base_next;
    end

    // Next state, datapath and memory control.
    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        fg_next     = fg_reg;
        bg_next     = bg_reg;
        top_next    = top_reg;
        crow_next   = crow_reg;
        ccol_next   = ccol_reg;
        pv_next     = pv_reg;
        pidx_next   = pidx_reg;
        slen_next   = slen_reg;
        inv_next    = inv_reg;
        sweep_next  = sweep_reg;
        sgr_next    = sgr_reg;
        pend_next   = pend_reg;
        pend_v_next = pend_v_reg;
        boot_next   = boot_reg;
        och_next    = och_reg;
        oat_next    = oat_reg;
        ring_base_next = ring_base_reg;
        we    = 1'b0;
        waddr = cur_addr;
        wdata = {attr, CH_SPACE};
        raddr = '0;
        byte_c = pend_v_reg ? pend_reg : data_byte;
        rr = '0;
        sv = pv_reg[sgr_reg];
        pi = (pidx_reg >= PIDX_W'(MAX_PARAMS)) ? PSEL_W'(MAX_PARAMS - 1)
                                              : pidx_reg[PSEL_W-1:0];
        prod = {4'd0, pv_reg[pi]} * 4'd10 + {10'd0, byte_c - CH_ZERO};
        case (state_reg)
            ST_CLEAR:
            begin
                we    = 1'b1;
                waddr = sweep_reg;
                if (sweep_reg == ADDR_W'(CELLS - 1))
                begin
                    sweep_next = '0;
                    // The pass after reset has no word to answer.
                    state_next = boot_reg ? ST_IDLE : ST_OUT;
                    boot_next  = 1'b0;
                end
                else
                    sweep_next = sweep_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if ((in_valid && !in_stall) || pend_v_reg)
                begin
                    och_next = '0;
                    oat_next = '0;
                    if (!pend_v_reg && func)
                    begin
                        if (read_column < COL_W'(COLUMNS) && read_row < ROW_W'(ROWS))
                        begin
                            raddr = addr_of(read_row, top_reg, read_column);
                            state_next = ST_READ;
                        end
                        else
                            state_next = ST_OUT;
                    end
                    else
                    begin
                        pend_v_next = 1'b0;
                        state_next  = ST_OUT;
                        case (mode_reg)
                            MODE_ESC:
                            begin
                                if (byte_c == CH_LBRK)
                                begin
                                    mode_next = MODE_CSI;
                                    for (int i = 0; i < MAX_PARAMS; i++)
                                        pv_next[i] = '0;
                                    pidx_next = '0;
                                    slen_next = '0;
                                    inv_next  = 1'b0;
                                end
                                else
                                begin
                                    // Print the ESC, then replay this byte from ground.
                                    mode_next   = MODE_GROUND;
                                    pend_next   = byte_c;
                                    pend_v_next = 1'b1;
                                    we    = 1'b1;
                                    wdata = {attr, CH_ESC};
                                    state_next = ST_GLYPH;
                                end
                            end
                            MODE_CSI:
                            begin
                                if (byte_c >= CH_AT && byte_c <= CH_TILDE)
                                begin
                                    mode_next = MODE_GROUND;
                                    if (!inv_reg && slen_reg != SLEN_W'(SEQ_BUFFER_BYTES - 1))
                                    begin
                                        if (byte_c == FIN_H || byte_c == FIN_F)
                                        begin
                                            crow_next = pos_row(pv_reg[0]);
                                            ccol_next = (MAX_PARAMS > 1 && pidx_reg >= 1)
                                                ? pos_col(pv_reg[1 % MAX_PARAMS]) : '0;
                                        end
                                        else if (byte_c == FIN_J)
                                        begin
                                            if (pv_reg[0] == PVAL_W'(2))
                                            begin
                                                top_next   = '0;
                                                crow_next  = '0;
                                                ccol_next  = '0;
                                                sweep_next = '0;
                                                state_next = ST_CLEAR;
                                            end
                                        end
                                        else if (byte_c == FIN_M)
                                        begin
                                            sgr_next   = '0;
                                            state_next = ST_SGR;
                                        end
                                    end
                                end
                                else
                                begin
                                    if (slen_reg < SLEN_W'(SEQ_BUFFER_BYTES - 1))
                                        slen_next = slen_reg + 1'b1;
                                    if (byte_c >= CH_ZERO && byte_c <= CH_NINE)
                                        pv_next[pi] = (prod > (PVAL_W+4)'(PARAM_MAX))
                                            ? PARAM_MAX : prod[PVAL_W-1:0];
                                    else if (byte_c == CH_SEMI)
                                    begin
                                        if (pidx_reg + 1'b1 >= PIDX_W'(MAX_PARAMS))
                                            inv_next = 1'b1;
                                        else
                                            pidx_next = pidx_reg + 1'b1;
                                    end
                                    else
                                        inv_next = 1'b1;
                                end
                            end
                            default:
                            begin
                                if (byte_c == CH_ESC)
                                    mode_next = MODE_ESC;
                                else if (byte_c == CH_LF)
                                begin
                                    ccol_next  = '0;
                                    state_next = ST_GLYPH;
                                    pend_next  = byte_c;
                                end
                                else if (byte_c == CH_CR)
                                    ccol_next = '0;
                                else if (byte_c == CH_BS)
                                begin
                                    if (ccol_reg != '0)
                                    begin
                                        ccol_next = ccol_reg - 1'b1;
                                        we    = 1'b1;
                                        waddr = cur_addr - 1'b1;
                                    end
                                end
                                else
                                begin
                                    we    = 1'b1;
                                    wdata = {attr, byte_c};
                                    state_next = ST_GLYPH;
                                end
                            end
                        endcase
                    end
                end
            end
            ST_GLYPH:
            begin
                // Advance after a write or newline; wrap and scroll as needed.
                state_next = pend_v_reg ? ST_IDLE : ST_OUT;
                if (pend_reg == CH_LF && !pend_v_reg)
                    rr = crow_reg + 1'b1;
                else if (ccol_reg == COL_W'(COLUMNS - 1))
                begin
                    ccol_next = '0;
                    rr = crow_reg + 1'b1;
                end
                else
                begin
                    ccol_next = ccol_reg + 1'b1;
                    rr = crow_reg;
                end
                pend_next = pend_v_reg ? pend_reg : 8'd0;
                if (rr >= ROW_W'(ROWS))
                begin
                    crow_next  = ROW_W'(ROWS - 1);
                    ring_base_next = addr_of('0, top_reg, '0);
                    sweep_next = '0;
                    state_next = ST_SCROLL;
                end
                else
                    crow_next = rr;
            end
            ST_SCROLL:
            begin
                we    = 1'b1;
                waddr = ring_base_reg + sweep_reg;
                if (sweep_reg == ADDR_W'(COLUMNS - 1))
                begin
                    sweep_next = '0;
                    top_next   = (top_reg == ROW_W'(ROWS - 1)) ? '0 : top_reg + 1'b1;
                    state_next = pend_v_reg ? ST_IDLE : ST_OUT;
                end
                else
                    sweep_next = sweep_reg + 1'b1;
            end
            ST_SGR:
            begin
                if (sv == '0)
                begin
                    fg_next = dfg_reg;
                    bg_next = dbg_reg;
                end
                else if (sv >= PVAL_W'(30) && sv <= PVAL_W'(37))
                    fg_next = sv[3:0] - 4'd14;
                else if (sv >= PVAL_W'(40) && sv <= PVAL_W'(47))
                    bg_next = sv[3:0] - 4'd8;
                if ({1'b0, sgr_reg} >= PIDX_W'(pidx_reg) ||
                    sgr_reg == PSEL_W'(MAX_PARAMS - 1))
                    state_next = ST_OUT;
                else
                    sgr_next = sgr_reg + 1'b1;
            end
            ST_READ:
            begin
                och_next   = rd_data_reg[7:0];
                oat_next   = rd_data_reg[15:8];
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n) crow_reg < ROW_W'(ROWS))
        else $error("cursor row out of range");
    assert property (@(posedge clk) disable iff (!rst_n) ccol_reg < COL_W'(COLUMNS))
        else $error("cursor column out of range");
    assert property (@(posedge clk) disable iff (!rst_n) top_reg < ROW_W'(ROWS))
        else $error("top row offset out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(cursor_column)))
        else $error("result lost while stalled");
endmodule

@@ tb/ansi_text_terminal_tb.sv @@
// Testbench for ansi_text_terminal: random and directed byte streams and cell reads,
// checked against a behavioral screen model in a scoreboard class. Uses att_pkg.
`timescale 1ns / 1ps
module ansi_text_terminal_tb;
    import att_pkg::*;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [7:0]       chr;
        logic [7:0]       attr;
    } term_word_t;

    class term_scoreboard;
        logic [15:0]       cells [CELLS];
        int unsigned       top_off, cur_col, cur_row;
        logic [3:0]        fg, bg, def_fg, def_bg;
        mode_t             mode;
        int unsigned       pvals [MAX_PARAMS];
        int unsigned       pidx, slen;
        bit                bad;
        term_word_t        pending [$];
        int                errors;

        function void init();
            def_fg = 4'd15;
            def_bg = 4'd1;
            fg = def_fg;
            bg = def_bg;
            clear_all();
            mode = MODE_GROUND;
            foreach (pvals[i]) pvals[i] = 0;
            pidx = 0;
            slen = 0;
            bad = 1'b0;
            errors = 0;
        endfunction

        function logic [15:0] blank();
            return {bg, fg, CH_SPACE};
        endfunction

        function void clear_all();
            foreach (cells[i]) cells[i] = blank();
            top_off = 0;
            cur_col = 0;
            cur_row = 0;
        endfunction

        function int unsigned addr(int unsigned r, int unsigned c);
            return ((r + top_off) % ROWS) * COLUMNS + c;
        endfunction

        function void put_glyph(logic [7:0] c);
            if (c == CH_LF) begin
                cur_row++;
                cur_col = 0;
            end else if (c == CH_CR) begin
                cur_col = 0;
            end else if (c == CH_BS) begin
                if (cur_col > 0) begin
                    cur_col--;
                    cells[addr(cur_row, cur_col)] = blank();
                end
            end else begin
                cells[addr(cur_row, cur_col)] = {bg, fg, c};
                cur_col++;
            end
            if (cur_col >= COLUMNS) begin
                cur_col = 0;
                cur_row++;
            end
            if (cur_row >= ROWS) begin
                for (int i = 0; i < COLUMNS; i++) cells[top_off * COLUMNS + i] = blank();
                top_off = (top_off + 1) % ROWS;
                cur_row = ROWS - 1;
            end
        endfunction

        function int unsigned clamp_pos(int unsigned v, int unsigned lim);
            if (v == 0) v = 1;
            v--;
            return (v >= lim) ? lim - 1 : v;
        endfunction

        function void run_csi(logic [7:0] fin);
            int unsigned v;
            if (fin == FIN_H || fin == FIN_F) begin
                cur_row = clamp_pos(pvals[0], ROWS);
                cur_col = (pidx >= 1) ? clamp_pos(pvals[1], COLUMNS) : 0;
            end else if (fin == FIN_J) begin
                if (pvals[0] == 2) clear_all();
            end else if (fin == FIN_M) begin
                for (int i = 0; i <= pidx && i < MAX_PARAMS; i++) begin
                    v = pvals[i];
                    if (v == 0) begin
                        fg = def_fg;
                        bg = def_bg;
                    end else if (v >= 30 && v <= 37) fg = 4'(v - 30);
                    else if (v >= 40 && v <= 47) bg = 4'(v - 40);
                end
            end
        endfunction

        function void ground_byte(logic [7:0] b);
            if (b == CH_ESC) mode = MODE_ESC;
            else put_glyph(b);
        endfunction

        function void feed(logic [7:0] b);
            int unsigned k;
            if (mode == MODE_ESC) begin
                if (b == CH_LBRK) begin
                    mode = MODE_CSI;
                    foreach (pvals[i]) pvals[i] = 0;
                    pidx = 0;
                    slen = 0;
                    bad = 1'b0;
                end else begin
                    mode = MODE_GROUND;
                    put_glyph(CH_ESC);
                    ground_byte(b);
                end
            end else if (mode == MODE_CSI) begin
                if (b >= CH_AT && b <= CH_TILDE) begin
                    mode = MODE_GROUND;
                    if (!bad && slen + 1 <= SEQ_BUFFER_BYTES - 1) run_csi(b);
                    return;
                end
                if (slen < SEQ_BUFFER_BYTES - 1) slen++;
                if (b >= CH_ZERO && b <= CH_NINE) begin
                    k = (pidx < MAX_PARAMS) ? pidx : MAX_PARAMS - 1;
                    pvals[k] = pvals[k] * 10 + (b - CH_ZERO);
                    if (pvals[k] > PARAM_MAX) pvals[k] = PARAM_MAX;
                end else if (b == CH_SEMI) begin
                    if (pidx + 1 >= MAX_PARAMS) bad = 1'b1;
                    else pidx++;
                end else begin
                    bad = 1'b1;
                end
            end else begin
                ground_byte(b);
            end
        endfunction

        function void write_reg(logic idx, logic [3:0] val);
            if (idx == CFG_FG) def_fg = val;
            else def_bg = val;
        endfunction

        function void note_word(logic f, logic [7:0] b, logic [6:0] rc, logic [4:0] rr);
            term_word_t w;
            logic [15:0] c;
            w.chr = '0;
            w.attr = '0;
            if (!f) feed(b);
            else if (rc < COLUMNS && rr < ROWS) begin
                c = cells[addr(rr, rc)];
                w.chr = c[7:0];
                w.attr = c[15:8];
            end
            w.col = COL_W'(cur_col);
            w.row = ROW_W'(cur_row);
            pending.push_back(w);
        endfunction

        function void check_word(term_word_t got);
            term_word_t e;
            if (pending.size() == 0) begin
                $error("unexpected result word");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.col !== e.col) begin
                $error("cursor_column exp %0d got %0d", e.col, got.col);
                errors++;
            end
            if (got.row !== e.row) begin
                $error("cursor_row exp %0d got %0d", e.row, got.row);
                errors++;
            end
            if (got.chr !== e.chr) begin
                $error("cell_character exp %0h got %0h", e.chr, got.chr);
                errors++;
            end
            if (got.attr !== e.attr) begin
                $error("cell_attribute exp %0h got %0h", e.attr, got.attr);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_valid = 0, cfg_index = 0;
    logic [3:0] cfg_data = 0;
    logic cfg_ready;
    logic in_valid = 0, in_stall;
    logic func = 0;
    logic [7:0] data_byte = 0;
    logic [6:0] read_column = 0;
    logic [4:0] read_row = 0;
    logic out_valid, out_stall = 0;
    logic [COL_W-1:0] cursor_column;
    logic [ROW_W-1:0] cursor_row;
    logic [7:0] cell_character, cell_attribute;

    term_scoreboard sb = new();
    int burst_left = 0;
    bit stall_mode = 0;

    always #5 clk = ~clk;

    ansi_text_terminal u_top (.*);

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_word({cursor_column, cursor_row, cell_character, cell_attribute});
        if (!stall_mode) out_stall <= 1'b0;
        else out_stall <= ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
    end

    task automatic send_word(logic f, logic [7:0] b, logic [6:0] rc, logic [4:0] rr);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_valid <= 1'b1;
        func <= f;
        data_byte <= b;
        read_column <= rc;
        read_row <= rr;
        sb.note_word(f, b, rc, rr);
        do @(posedge clk); while (in_stall);
    endtask

    task automatic put_byte(logic [7:0] b);
        send_word(1'b0, b, 7'($urandom), 5'($urandom));
    endtask

    task automatic put_str(string s);
        foreach (s[i]) put_byte(s[i]);
    endtask

    task automatic read_cell(logic [6:0] c, logic [4:0] r);
        send_word(1'b1, 8'($urandom), c, r);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (2100) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [3:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        sb.write_reg(idx, val);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_csi();
        int n;
        string fins;
        fins = "HfJmmA@~";
        put_byte(CH_ESC);
        put_byte(CH_LBRK);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: put_str($sformatf("%0d", $urandom_range(0, 50)));
                1: put_str($sformatf("%0d", $urandom_range(30, 47)));
                2: put_str($sformatf("%0d", $urandom_range(0, 99999)));
                default: ;
            endcase
            if (i != n - 1) put_byte(CH_SEMI);
        end
        if ($urandom_range(0, 15) == 0) put_byte(8'($urandom_range(0, 47)));
        if ($urandom_range(0, 4) == 0) put_str("2");
        put_byte(fins[$urandom_range(0, 7)]);
    endtask

    initial begin
        #100ms;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        sb.init();
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        put_str("A");
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(CH_BS);
        put_byte(CH_BS);
        put_byte(CH_BS);
        put_byte(CH_CR);
        put_byte(CH_LF);
        put_byte(CH_ESC);
        put_str("x");
        put_str("\033[31;42mZ");
        put_str("\033[99999;200H");
        put_str("\033[1;2;3;4;5;6;7;8;9mQ");
        put_str("\033[3?1mQ");
        put_str("\033[0m\033[f");
        read_cell(7'd0, 5'd0);
        read_cell(7'd79, 5'd24);
        read_cell(7'd127, 5'd31);
        read_cell(7'd1, 5'd0);
        put_str("\033[2J");
        drain();

        write_reg(CFG_FG, 4'd0);
        write_reg(CFG_BG, 4'd15);
        put_str("\033[1111111111111111111111111111111111m");
        put_str("\033[0mB\033[2J");
        read_cell(7'd5, 5'd5);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            for (int k = 0; k < 135; k++) begin
                case ($urandom_range(0, 9))
                    0, 1: random_csi();
                    2: read_cell(7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)));
                    3: read_cell(7'($urandom_range(0, 79)), 5'($urandom_range(0, 24)));
                    4: put_byte($urandom_range(0, 2) == 0 ? CH_LF : CH_CR);
                    5: put_byte(8'($urandom));
                    default: put_byte(8'($urandom_range(32, 126)));
                endcase
                if (k == 50) drain();
            end
            drain();
            write_reg(CFG_FG, 4'($urandom));
            write_reg(CFG_BG, 4'($urandom));
            put_str("\033[m");
        end

        drain();
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

@@ filelist.f @@
hdl/att_pkg.sv
hdl/ansi_text_terminal.sv
tb/ansi_text_terminal_tb.sv
